// File: hdl/gffc_pkg.sv
package gffc_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;
    localparam int TOTAL_W      = 12;
    localparam int CFG_W        = 7;

    localparam logic [1:0] KIND_OPEN   = 2'd0;
    localparam logic [1:0] KIND_WALL   = 2'd1;
    localparam logic [1:0] KIND_SOURCE = 2'd2;
    localparam logic [1:0] KIND_SPARE  = 2'd3;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // neighbor order: up, down, left, right
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_POP,
        ST_POP_WAIT,
        ST_NB_RD,
        ST_NB_CHK,
        ST_ACCUM,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_cell;
        logic clear_start;
        logic clear_step;
        logic scan_start;
        logic scan_read;
        logic scan_push;
        logic scan_next;
        logic pop_read;
        logic pop_take;
        logic nb_read;
        logic nb_push;
        logic nb_next;
        logic accum;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic scan_hit;
        logic stack_empty;
        logic nb_ok;
        logic nb_last;
    } status_t;

endpackage

// File: hdl/gffc_if.sv
interface gffc_in_if;
    import gffc_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] cell_kind;
    logic       last_cell;
    modport source (output valid, cell_kind, last_cell, input ready);
    modport sink (input valid, cell_kind, last_cell, output ready);
endinterface

interface gffc_out_if;
    import gffc_pkg::*;
    logic        valid;
    logic        ready;
    logic [11:0] floors_replaced;
    modport source (output valid, floors_replaced, input ready);
    modport sink (input valid, floors_replaced, output ready);
endinterface

// File: hdl/gffc_ctrl.sv
module gffc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  gffc_pkg::status_t sts,
    output gffc_pkg::cmd_t    cmd
);
    import gffc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_cell = 1'b1;
                    if (in_last)
                    begin
                        cmd.clear_start = 1'b1;
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    cmd.scan_start = 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.scan_read = 1'b1;
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                if (sts.scan_hit)
                begin
                    cmd.scan_push = 1'b1;
                    state_next = ST_POP;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_POP:
            begin
                if (sts.stack_empty)
                begin
                    state_next = ST_ACCUM;
                end
                else
                begin
                    cmd.pop_read = 1'b1;
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                cmd.pop_take = 1'b1;
                state_next = ST_NB_RD;
            end
            ST_NB_RD:
            begin
                cmd.nb_read = 1'b1;
                state_next = ST_NB_CHK;
            end
            ST_NB_CHK:
            begin
                cmd.nb_push = sts.nb_ok;
                cmd.nb_next = 1'b1;
                state_next = sts.nb_last ? ST_POP : ST_NB_RD;
            end
            ST_ACCUM:
            begin
                cmd.accum = 1'b1;
                cmd.scan_next = 1'b1;
                state_next = ST_SCAN_RD;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !out_ready) |=> state_reg == ST_EMIT)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("load overlaps emit");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_read |=> cmd.pop_take)
        else $error("pop not completed");

endmodule

// File: hdl/gffc_datapath.sv
module gffc_datapath #(
    parameter int MAX_ROWS = gffc_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gffc_pkg::MAX_COLS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_idx,
    input  logic [gffc_pkg::CFG_W-1:0] cfg_data,
    input  logic [1:0]                 cell_kind,
    input  gffc_pkg::cmd_t             cmd,
    output gffc_pkg::status_t          sts,
    output logic [gffc_pkg::TOTAL_W-1:0] total
);
    import gffc_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int RIW   = $clog2(MAX_ROWS);
    localparam int CIW   = $clog2(MAX_COLS);
    localparam int DW    = AW + 1;
    localparam int SW    = RIW + CIW;

    logic [CFG_W-1:0] rows_cfg_reg, cols_cfg_reg;
    logic [RW-1:0]    rows_reg;
    logic [CW-1:0]    cols_reg;

    logic [1:0]  cell_mem [CELLS];
    logic        vis_mem  [CELLS];
    logic [SW-1:0] stk_mem [CELLS];

    logic [DW-1:0] load_pos_reg;
    logic [DW-1:0] depth_reg;
    logic [DW-1:0] clr_reg;
    logic [RIW-1:0] sr_reg, qr_reg;
    logic [CIW-1:0] sc_reg, qc_reg;
    logic [DW-1:0]  sp_reg;
    logic [1:0]     dir_reg;
    logic [AW:0]    reached_reg;
    logic [TOTAL_W:0] total_reg;
    logic [1:0]     kind_rd_reg;
    logic           vis_rd_reg;
    logic [SW-1:0]  stk_rd_reg;
    logic [DW-1:0]  rd_addr_reg;
    logic           nb_in_reg;

    // clamped dimensions
    logic [RW-1:0] rows_c;
    logic [CW-1:0] cols_c;
    always_comb
    begin
        if (rows_cfg_reg == '0)
            rows_c = RW'(1);
        else if (32'(rows_cfg_reg) > MAX_ROWS)
            rows_c = RW'(MAX_ROWS);
        else
            rows_c = RW'(rows_cfg_reg);
        if (cols_cfg_reg == '0)
            cols_c = CW'(1);
        else if (32'(cols_cfg_reg) > MAX_COLS)
            cols_c = CW'(MAX_COLS);
        else
            cols_c = CW'(cols_cfg_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= CFG_W'(64);
            cols_cfg_reg <= CFG_W'(64);
        end
        else if (cfg_we)
        begin
            if (cfg_idx == CFG_ROWS)
                rows_cfg_reg <= cfg_data;
            else
                cols_cfg_reg <= cfg_data;
        end
    end

    logic [AW+1:0] n_cells;
    assign n_cells = (AW+2)'(rows_c) * (AW+2)'(cols_c);

    // neighbor coordinate of the popped cell
    logic [RIW-1:0] nr;
    logic [CIW-1:0] nc;
    logic           nb_valid;
    always_comb
    begin
        nr = qr_reg;
        nc = qc_reg;
        nb_valid = 1'b0;
        case (dir_reg)
            DIR_UP:
            begin
                nb_valid = qr_reg != '0;
                nr = qr_reg - RIW'(1);
            end
            DIR_DOWN:
            begin
                nb_valid = (RW'(qr_reg) + RW'(1)) < rows_reg;
                nr = qr_reg + RIW'(1);
            end
            DIR_LEFT:
            begin
                nb_valid = qc_reg != '0;
                nc = qc_reg - CIW'(1);
            end
            default:
            begin
                nb_valid = (CW'(qc_reg) + CW'(1)) < cols_reg;
                nc = qc_reg + CIW'(1);
            end
        endcase
    end

    logic [DW-1:0] nb_lin, scan_lin;
    assign nb_lin   = DW'(nr) * DW'(cols_reg) + DW'(nc);
    assign scan_lin = sp_reg;

    logic kind_ok_rd;
    assign kind_ok_rd = (rd_addr_reg < load_pos_reg);

    logic [1:0] kind_eff;
    assign kind_eff = kind_ok_rd ? kind_rd_reg : KIND_OPEN;

    // memories
    logic [DW-1:0] rd_addr;
    assign rd_addr = cmd.scan_read ? scan_lin : nb_lin;

    always_ff @(posedge clk)
    begin
        if (cmd.load_cell && load_pos_reg < DW'(n_cells))
            cell_mem[load_pos_reg[AW-1:0]] <= (cell_kind == KIND_SPARE) ? KIND_OPEN : cell_kind;
        kind_rd_reg <= cell_mem[rd_addr[AW-1:0]];
    end

    logic          vis_we;
    logic [AW-1:0] vis_wa;
    logic          vis_wd;
    always_comb
    begin
        vis_we = 1'b0;
        vis_wa = clr_reg[AW-1:0];
        vis_wd = 1'b0;
        if (cmd.clear_step && !sts.clear_done)
            vis_we = 1'b1;
        else if (cmd.scan_push)
        begin
            vis_we = 1'b1;
            vis_wa = rd_addr_reg[AW-1:0];
            vis_wd = 1'b1;
        end
        else if (cmd.nb_push)
        begin
            vis_we = 1'b1;
            vis_wa = rd_addr_reg[AW-1:0];
            vis_wd = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
            vis_mem[vis_wa] <= vis_wd;
        vis_rd_reg <= vis_mem[rd_addr[AW-1:0]];
    end

    // stack entries hold row and column, so a pop needs no division
    logic          stk_we;
    logic [AW-1:0] stk_wa;
    logic [SW-1:0] stk_wd;
    assign stk_we = cmd.scan_push || cmd.nb_push;
    assign stk_wa = depth_reg[AW-1:0];
    assign stk_wd = cmd.scan_push ? {sr_reg, sc_reg} : {nr, nc};

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_wa] <= stk_wd;
        stk_rd_reg <= stk_mem[AW'(depth_reg - DW'(1))];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg <= '0;
            depth_reg    <= '0;
            clr_reg      <= '0;
            sp_reg       <= '0;
            sr_reg       <= '0;
            sc_reg       <= '0;
            qr_reg       <= '0;
            qc_reg       <= '0;
            dir_reg      <= '0;
            reached_reg  <= '0;
            total_reg    <= '0;
            rows_reg     <= RW'(1);
            cols_reg     <= CW'(1);
            rd_addr_reg  <= '0;
            nb_in_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load_cell && load_pos_reg < DW'(n_cells))
                load_pos_reg <= load_pos_reg + DW'(1);
            if (cmd.clear_start)
            begin
                clr_reg <= '0;
                rows_reg <= rows_c;
                cols_reg <= cols_c;
            end
            if (cmd.clear_step && !sts.clear_done)
                clr_reg <= clr_reg + DW'(1);
            if (cmd.scan_start)
            begin
                sp_reg <= '0;
                sr_reg <= '0;
                sc_reg <= '0;
                total_reg <= '0;
                depth_reg <= '0;
            end
            if (cmd.scan_read)
                rd_addr_reg <= scan_lin;
            if (cmd.nb_read)
            begin
                rd_addr_reg <= nb_lin;
                nb_in_reg <= nb_valid;
            end
            if (cmd.scan_next)
            begin
                sp_reg <= sp_reg + DW'(1);
                if (CW'(sc_reg) + CW'(1) == cols_reg)
                begin
                    sc_reg <= '0;
                    sr_reg <= sr_reg + RIW'(1);
                end
                else
                    sc_reg <= sc_reg + CIW'(1);
            end
            if (cmd.scan_push)
            begin
                depth_reg <= depth_reg + DW'(1);
                reached_reg <= '0;
                qr_reg <= sr_reg;
                qc_reg <= sc_reg;
            end
            if (cmd.pop_read)
                depth_reg <= depth_reg - DW'(1);
            if (cmd.pop_take)
            begin
                qr_reg <= stk_rd_reg[SW-1:CIW];
                qc_reg <= stk_rd_reg[CIW-1:0];
                dir_reg <= DIR_UP;
                reached_reg <= reached_reg + (AW+1)'(1);
            end
            if (cmd.nb_push)
                depth_reg <= depth_reg + DW'(1);
            if (cmd.nb_next)
                dir_reg <= dir_reg + 2'd1;
            if (cmd.accum)
            begin
                if (total_reg + (TOTAL_W+1)'(reached_reg - (AW+1)'(1)) > (TOTAL_W+1)'(4095))
                    total_reg <= (TOTAL_W+1)'(4095);
                else
                    total_reg <= total_reg + (TOTAL_W+1)'(reached_reg - (AW+1)'(1));
            end
            if (cmd.finish)
                load_pos_reg <= '0;
        end
    end

    assign sts.clear_done  = clr_reg == DW'(CELLS);
    assign sts.scan_done   = sp_reg == DW'(n_cells);
    assign sts.scan_hit    = (kind_eff == KIND_SOURCE) && !vis_rd_reg;
    assign sts.stack_empty = depth_reg == '0;
    assign sts.nb_ok       = nb_in_reg && !vis_rd_reg && (kind_eff != KIND_WALL);
    assign sts.nb_last     = dir_reg == DIR_RIGHT;
    assign total           = total_reg[TOTAL_W-1:0];

endmodule

// File: hdl/grid_flood_fill_counter.sv
// loading: grid cells load at one per cycle while in the load state; from the final cell
// the block clears the visited map, scans the grid and floods from each unvisited source
// throughput: one grid at a time; the input stalls from the final cell until the total
// word is taken
// reset: rst_n asynchronous low; dimensions return to 64 by 64, load position and
// stack depth to zero; the visited map is swept clear before each fill
module grid_flood_fill_counter #(
    parameter int MAX_ROWS = gffc_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gffc_pkg::MAX_COLS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_idx,
    input  logic [gffc_pkg::CFG_W-1:0] cfg_data,
    gffc_in_if.sink                    cells,
    gffc_out_if.source                 result
);
    import gffc_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // controller sequences load, clear, scan and walk
    gffc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cells.valid),
        .in_last   (cells.last_cell),
        .in_ready  (cells.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath holds the grid, visited map and walk stack
    gffc_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .cell_kind (cells.cell_kind),
        .cmd       (cmd),
        .sts       (sts),
        .total     (result.floors_replaced)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import gffc_pkg::*;

    localparam int CELLS     = MAX_ROWS_DEF * MAX_COLS_DEF;
    localparam int STALL_MAX = 200000;   // idle cycles before the watchdog gives up
    localparam int DRAIN     = 60;       // settle time after the last result

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [0:0]       cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    gffc_in_if  cells_if ();
    gffc_out_if result_if ();

    grid_flood_fill_counter u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cells    (cells_if.sink),
        .result   (result_if.source)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // shadow copy of the block: dimensions as written, cells of the grid being loaded
    logic [CFG_W-1:0] rows_shadow;
    logic [CFG_W-1:0] cols_shadow;
    logic [1:0]       kind_mem [CELLS];
    int               load_pos;

    // totals still owed by the block, oldest first
    logic [TOTAL_W-1:0] totals_due [$];

    int fail_count;
    int words_sent;
    int grids_sent;
    int totals_seen;
    int idle_cycles;

    // idling knobs, percent of cycles
    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold;        // long receiver hold-off, counted down in the receiver process

    function automatic int clamp_dim(logic [CFG_W-1:0] v, int hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // kind of a linear position; anything not loaded in this grid reads as floor
    function automatic logic [1:0] kind_of(int p);
        if (p >= load_pos)
            return KIND_OPEN;
        return kind_mem[p];
    endfunction

    // 4-connected fill from every unvisited source, summing reached cells minus one
    function automatic logic [TOTAL_W-1:0] flood_total();
        int  rows;
        int  cols;
        int  n;
        int  total;
        int  reached;
        int  q;
        int  nb [4];
        int  nb_cnt;
        bit  seen [CELLS];
        int  walk [$];
        rows  = clamp_dim(rows_shadow, MAX_ROWS_DEF);
        cols  = clamp_dim(cols_shadow, MAX_COLS_DEF);
        n     = rows * cols;
        total = 0;
        for (int p = 0; p < n; p++)
        begin
            if (kind_of(p) != KIND_SOURCE || seen[p])
                continue;
            seen[p] = 1'b1;
            walk.push_back(p);
            reached = 0;
            while (walk.size() > 0)
            begin
                q = walk.pop_back();
                reached++;
                nb_cnt = 0;
                if (q / cols > 0)
                begin
                    nb[nb_cnt] = q - cols;
                    nb_cnt++;
                end
                if (q / cols + 1 < rows)
                begin
                    nb[nb_cnt] = q + cols;
                    nb_cnt++;
                end
                if (q % cols > 0)
                begin
                    nb[nb_cnt] = q - 1;
                    nb_cnt++;
                end
                if (q % cols + 1 < cols)
                begin
                    nb[nb_cnt] = q + 1;
                    nb_cnt++;
                end
                for (int k = 0; k < nb_cnt; k++)
                begin
                    if (!seen[nb[k]] && kind_of(nb[k]) != KIND_WALL)
                    begin
                        seen[nb[k]] = 1'b1;
                        walk.push_back(nb[k]);
                    end
                end
            end
            total += reached - 1;
            if (total > 4095)
                total = 4095;
        end
        return total[TOTAL_W-1:0];
    endfunction

    // one accepted cell word: store it, and on the final cell work out the total
    function automatic void take_cell(logic [1:0] kind, logic last);
        int n;
        n = clamp_dim(rows_shadow, MAX_ROWS_DEF) * clamp_dim(cols_shadow, MAX_COLS_DEF);
        if (kind == KIND_SPARE)
            kind = KIND_OPEN;
        if (load_pos < n)
        begin
            kind_mem[load_pos] = kind;
            load_pos++;
        end
        if (last)
        begin
            totals_due.push_back(flood_total());
            load_pos = 0;
        end
    endfunction

    // send one cell word; gaps before it at the sender's idle rate
    task automatic send_cell(logic [1:0] kind, logic last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cells_if.valid = 1'b0;
            @(negedge clk);
        end
        cells_if.valid     = 1'b1;
        cells_if.cell_kind = kind;
        cells_if.last_cell = last;
        @(posedge clk);
        while (!cells_if.ready)
            @(posedge clk);
        take_cell(kind, last);
        words_sent++;
        if (last)
            grids_sent++;
    endtask

    task automatic drop_valid();
        @(negedge clk);
        cells_if.valid = 1'b0;
    endtask

    // wait for every total, let the block settle back to loading
    task automatic wait_drained();
        drop_valid();
        wait (totals_due.size() == 0);
        repeat (DRAIN) @(negedge clk);
    endtask

    // register write, only while nothing is owed
    task automatic write_dim(logic [0:0] idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        @(posedge clk);
        if (idx == CFG_ROWS)
            rows_shadow = value;
        else
            cols_shadow = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_dims(logic [CFG_W-1:0] r, logic [CFG_W-1:0] c);
        wait_drained();
        write_dim(CFG_ROWS, r);
        write_dim(CFG_COLS, c);
    endtask

    function automatic logic [1:0] pick_kind(int wall_pct, int src_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < src_pct)
            return KIND_SOURCE;
        if (roll < src_pct + wall_pct)
            return KIND_WALL;
        if (roll < src_pct + wall_pct + 5)
            return KIND_SPARE;
        return KIND_OPEN;
    endfunction

    // len cells of random content, the last one flagged
    task automatic send_grid(int len, int wall_pct, int src_pct);
        for (int i = 0; i < len; i++)
            send_cell(pick_kind(wall_pct, src_pct), i == len - 1);
    endtask

    // directed: tiny grids, every kind, dimension corners, early and late final cells
    task automatic test_directed();
        set_dims(7'd1, 7'd1);
        send_cell(KIND_SOURCE, 1'b1);          // lone source, nothing to flood
        send_cell(KIND_WALL, 1'b1);
        set_dims(7'd2, 7'd2);
        send_cell(KIND_SOURCE, 1'b0);
        send_cell(KIND_SPARE, 1'b0);           // spare kind acts as floor
        send_cell(KIND_WALL, 1'b0);
        send_cell(KIND_OPEN, 1'b1);
        send_cell(KIND_SOURCE, 1'b0);          // grid ended early, rest reads as floor
        send_cell(KIND_OPEN, 1'b1);
        // too many cells: extras dropped, final cell still starts the fill
        for (int i = 0; i < 6; i++)
            send_cell(i == 0 ? KIND_OPEN : KIND_WALL, 1'b0);
        send_cell(KIND_SOURCE, 1'b1);
        // zero acts as one, oversize acts as the maximum
        set_dims(7'd0, 7'd127);
        send_cell(KIND_OPEN, 1'b0);
        send_cell(KIND_SOURCE, 1'b0);
        send_cell(KIND_WALL, 1'b0);
        send_cell(KIND_SOURCE, 1'b1);
        set_dims(7'd127, 7'd0);
        send_cell(KIND_SOURCE, 1'b0);
        send_cell(KIND_OPEN, 1'b1);
        // dimension change part way through a grid
        set_dims(7'd3, 7'd3);
        send_cell(KIND_SOURCE, 1'b0);
        send_cell(KIND_OPEN, 1'b0);
        send_cell(KIND_WALL, 1'b0);
        drop_valid();
        repeat (DRAIN) @(negedge clk);
        write_dim(CFG_COLS, 7'd2);
        send_cell(KIND_OPEN, 1'b1);
    endtask

    // full-size grid from a lone source as the only cell, the rest reads as floor:
    // the flood covers everything and gives the largest possible total
    task automatic test_full_grid();
        set_dims(7'd64, 7'd64);
        send_cell(KIND_SOURCE, 1'b1);
    endtask

    // random grids of small sizes, mostly well formed, some short or long
    task automatic test_random_grids(int words);
        int goal;
        int r;
        int c;
        int n;
        int len;
        goal = words_sent + words;
        while (words_sent < goal)
        begin
            if ($urandom_range(9) == 0)
            begin
                r = $urandom_range(127);
                c = $urandom_range(127);
                if (clamp_dim(r[CFG_W-1:0], 64) * clamp_dim(c[CFG_W-1:0], 64) > 256)
                    c = $urandom_range(3);
            end
            else
            begin
                r = $urandom_range(1, 8);
                c = $urandom_range(1, 8);
            end
            set_dims(r[CFG_W-1:0], c[CFG_W-1:0]);
            n = clamp_dim(r[CFG_W-1:0], 64) * clamp_dim(c[CFG_W-1:0], 64);
            for (int g = 0; g < 3; g++)
            begin
                case ($urandom_range(9))
                    0:       len = $urandom_range(1, n);
                    1:       len = n + $urandom_range(1, 4);
                    default: len = n;
                endcase
                send_grid(len, $urandom_range(0, 45), $urandom_range(2, 20));
            end
        end
    endtask

    // receiver holds off long while grids keep coming, so the input stalls
    task automatic test_backpressure();
        set_dims(7'd3, 7'd4);
        recv_hold = 20000;
        for (int g = 0; g < 4; g++)
            send_grid(12, 20, 15);
        wait_drained();                          // sender pauses until all totals are in
        send_grid(12, 10, 30);
    endtask

    // receiver: random ready, or held low during a hold-off
    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            result_if.ready = 1'b0;
            recv_hold--;
        end
        else
            result_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // result check against the oldest owed total
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            totals_seen++;
            if (totals_due.size() == 0)
            begin
                $error("floors_replaced: none expected, actual %0d", result_if.floors_replaced);
                fail_count++;
            end
            else if (result_if.floors_replaced !== totals_due[0])
            begin
                $error("floors_replaced: expected %0d, actual %0d",
                    totals_due[0], result_if.floors_replaced);
                fail_count++;
                void'(totals_due.pop_front());
            end
            else
                void'(totals_due.pop_front());
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge clk)
    begin
        if ((cells_if.valid && cells_if.ready) || (result_if.valid && result_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_MAX);
            $display("grid_flood_fill_counter regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = 1'b0;
        cfg_data           = '0;
        cells_if.valid     = 1'b0;
        cells_if.cell_kind = KIND_OPEN;
        cells_if.last_cell = 1'b0;
        result_if.ready    = 1'b0;
        rows_shadow        = 7'd64;
        cols_shadow        = 7'd64;
        load_pos           = 0;
        fail_count         = 0;
        words_sent         = 0;
        grids_sent         = 0;
        totals_seen        = 0;
        idle_cycles        = 0;
        recv_hold          = 0;
        send_idle_pct      = 11;
        recv_idle_pct      = 58;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_grids(320);
        test_backpressure();
        send_idle_pct = 58;
        recv_idle_pct = 11;
        test_random_grids(320);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_grids(320);
        test_full_grid();

        wait_drained();
        $display("covered %0d cell words in %0d grids, %0d totals checked", words_sent,
            grids_sent, totals_seen);
        $display("dimension corners, short and long grids, stalls and a full-size flood");
        if (fail_count == 0)
            $display("grid_flood_fill_counter regression: pass");
        else
            $display("grid_flood_fill_counter regression: fail");
        $finish;
    end

endmodule

// File: files.f
hdl/gffc_pkg.sv
hdl/gffc_if.sv
hdl/gffc_ctrl.sv
hdl/gffc_datapath.sv
hdl/grid_flood_fill_counter.sv
tb/tb_top.sv
